@@ src/spc_pkg.sv @@
package spc_pkg;

	localparam int MaxVerts = 8;
	localparam int IdxW = $clog2(MaxVerts);
	localparam int CntW = $clog2(MaxVerts + 1);

	localparam logic [1:0] ACT_LOAD_A = 2'd0;
	localparam logic [1:0] ACT_LOAD_B = 2'd1;
	localparam logic [1:0] ACT_TEST   = 2'd2;
	localparam logic [1:0] ACT_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic               collided;
		logic signed [15:0] push_x;
		logic signed [15:0] push_y;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic            load_a;
		logic            load_b;
		logic            clear;
		logic            edge_start;
		logic            use_b;
		logic [IdxW-1:0] edge_idx;
		logic            sqrt_start;
		logic            div_start;
		logic            proj_start;
		logic            proj_step;
		logic            proj_b;
		logic [IdxW-1:0] proj_idx;
		logic            axis_eval;
		logic            sum_step;
		logic            sum_b;
		logic [IdxW-1:0] sum_idx;
		logic            dir_calc;
		logic            push_calc;
		logic            push_fin;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CntW-1:0] count_a;
		logic [CntW-1:0] count_b;
		logic            edge_zero;
		logic            sqrt_done;
		logic            div_done;
		logic            separated;
		logic            have;
	} dp_stat_t;

endpackage

@@ src/spc_if.sv @@
interface spc_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/spc_datapath.sv @@
module spc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  spc_pkg::dp_cmd_t    cmd,
	input  logic signed [15:0]  in_x,
	input  logic signed [15:0]  in_y,
	output spc_pkg::dp_stat_t   stat,
	output spc_pkg::out_item_t  res
);
	logic [31:0] mem_a [spc_pkg::MaxVerts];
	logic [31:0] mem_b [spc_pkg::MaxVerts];
	logic [spc_pkg::CntW-1:0] cnt_a_q, cnt_b_q;

	// edge / normal
	logic signed [17:0] nx_q, ny_q;
	logic [35:0] l2_q;
	// sqrt
	logic [51:0] sq_v_q;
	logic [51:0] sq_r_q;
	logic [51:0] sq_bit_q;
	logic sq_busy_q;
	// divide (two quotients, shared restoring unit run for x then y)
	logic [40:0] dv_rem_q;
	logic [40:0] dv_num_q;
	logic [40:0] dv_quo_q;
	logic [5:0]  dv_cnt_q;
	logic        dv_sel_q;
	logic        dv_busy_q;
	logic        dv_negx_q, dv_negy_q;
	logic signed [15:0] ux_q, uy_q;
	// projection
	logic signed [33:0] amin_q, amax_q, bmin_q, bmax_q;
	logic signed [33:0] best_q;
	logic signed [15:0] bux_q, buy_q;
	logic have_q, sep_q;
	// centroids
	logic signed [19:0] sax_q, say_q, sbx_q, sby_q;
	logic signed [24:0] dx_q, dy_q;
	logic signed [41:0] dot_q;
	logic signed [49:0] px_q, py_q;
	logic [15:0] out_x_q, out_y_q;
	logic collided_q;

	logic [spc_pkg::IdxW-1:0] nxt_idx;
	logic [31:0] v0, v1, pv, sv;
	logic [spc_pkg::CntW-1:0] ncnt;
	logic signed [17:0] ex, ey;
	logic signed [33:0] proj;
	logic signed [33:0] p1, p2, pen_c;

	function automatic logic [15:0] fin(input logic signed [49:0] v, input logic neg);
		logic [49:0] m;
		logic signed [23:0] r;
		m = v[49] ? 50'(-v) : 50'(v);
		m = (m + 50'h800_0000) >> 28;
		r = v[49] ? -24'(m) : 24'(m);
		if (neg) r = -r;
		if (r > 24'sd32767) r = 24'sd32767;
		if (r < -24'sd32768) r = -24'sd32768;
		return r[15:0];
	endfunction

	assign ncnt = cmd.use_b ? cnt_b_q : cnt_a_q;
	assign nxt_idx = ({1'b0, cmd.edge_idx} + 1'b1 == ncnt) ? '0 : cmd.edge_idx + 1'b1;
	assign v0 = cmd.use_b ? mem_b[cmd.edge_idx] : mem_a[cmd.edge_idx];
	assign v1 = cmd.use_b ? mem_b[nxt_idx] : mem_a[nxt_idx];
	assign ex = 18'(signed'(v1[31:16])) - 18'(signed'(v0[31:16]));
	assign ey = 18'(signed'(v1[15:0])) - 18'(signed'(v0[15:0]));

	assign pv = cmd.proj_b ? mem_b[cmd.proj_idx] : mem_a[cmd.proj_idx];
	assign proj = 34'(signed'(pv[31:16])) * 34'(ux_q) + 34'(signed'(pv[15:0])) * 34'(uy_q);
	assign sv = cmd.sum_b ? mem_b[cmd.sum_idx] : mem_a[cmd.sum_idx];

	assign p1 = amax_q - bmin_q;
	assign p2 = bmax_q - amin_q;
	assign pen_c = (p2 < p1) ? p2 : p1;

	always_ff @(posedge clk) begin
		if (cmd.load_a && cnt_a_q < spc_pkg::CntW'(spc_pkg::MaxVerts))
			mem_a[cnt_a_q[spc_pkg::IdxW-1:0]] <= {in_x, in_y};
		if (cmd.load_b && cnt_b_q < spc_pkg::CntW'(spc_pkg::MaxVerts))
			mem_b[cnt_b_q[spc_pkg::IdxW-1:0]] <= {in_x, in_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sq_busy_q <= 1'b0;
			dv_busy_q <= 1'b0;
			have_q <= 1'b0;
			sep_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				have_q <= 1'b0;
				sep_q <= 1'b0;
			end else begin
				if (cmd.load_a && cnt_a_q < spc_pkg::CntW'(spc_pkg::MaxVerts))
					cnt_a_q <= cnt_a_q + 1'b1;
				if (cmd.load_b && cnt_b_q < spc_pkg::CntW'(spc_pkg::MaxVerts))
					cnt_b_q <= cnt_b_q + 1'b1;
			end
			if (cmd.sqrt_start)
				sq_busy_q <= 1'b1;
			else if (sq_busy_q && sq_bit_q == '0)
				sq_busy_q <= 1'b0;
			if (cmd.div_start)
				dv_busy_q <= 1'b1;
			else if (dv_busy_q && dv_cnt_q == '0 && dv_sel_q)
				dv_busy_q <= 1'b0;
			if (cmd.axis_eval) begin
				if (!(amin_q < bmax_q && bmin_q < amax_q))
					sep_q <= 1'b1;
				else if (!have_q || pen_c < best_q)
					have_q <= 1'b1;
			end
		end
	end

	// edge normal and squared length
	always_ff @(posedge clk) begin
		if (cmd.edge_start) begin
			nx_q <= -ey;
			ny_q <= ex;
			l2_q <= 36'(ey) * 36'(ey) + 36'(ex) * 36'(ex);
		end
	end

	// bit-serial square root of l2 * 2^16
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q   <= {l2_q, 16'h0};
			sq_r_q   <= '0;
			sq_bit_q <= 52'h4_0000_0000_0000;
		end else if (sq_busy_q && sq_bit_q != '0) begin
			if ({1'b0, sq_v_q} >= {1'b0, sq_r_q} + {1'b0, sq_bit_q}) begin
				sq_v_q <= sq_v_q - (sq_r_q + sq_bit_q);
				sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
			end else begin
				sq_r_q <= sq_r_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// restoring divide |n| * 2^22 / lenq, x first then y
	always_ff @(posedge clk) begin
		if (cmd.div_start || (dv_busy_q && dv_cnt_q == '0 && !dv_sel_q)) begin
			dv_sel_q <= !cmd.div_start;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			dv_cnt_q <= 6'd41;
			if (cmd.div_start) begin
				dv_num_q  <= {5'(0), 36'(nx_q[17] ? -nx_q : nx_q)} << 22;
				dv_negx_q <= nx_q[17];
			end else begin
				dv_num_q  <= {5'(0), 36'(ny_q[17] ? -ny_q : ny_q)} << 22;
				dv_negy_q <= ny_q[17];
				ux_q <= dv_negx_q ? -16'(dv_quo_q) : 16'(dv_quo_q);
			end
		end else if (dv_busy_q) begin
			logic [41:0] tr;
			tr = {dv_rem_q, dv_num_q[40]} - {16'h0, sq_r_q[25:0]};
			if (!tr[41]) begin
				dv_rem_q <= tr[40:0];
				dv_quo_q <= {dv_quo_q[39:0], 1'b1};
			end else begin
				dv_rem_q <= {dv_rem_q[39:0], dv_num_q[40]};
				dv_quo_q <= {dv_quo_q[39:0], 1'b0};
			end
			dv_num_q <= dv_num_q << 1;
			if (dv_cnt_q != '0)
				dv_cnt_q <= dv_cnt_q - 1'b1;
		end
		if (dv_busy_q && dv_cnt_q == '0 && dv_sel_q)
			uy_q <= dv_negy_q ? -16'(dv_quo_q) : 16'(dv_quo_q);
	end

	// projection span, best axis, centroid sums, push
	always_ff @(posedge clk) begin
		if (cmd.proj_start) begin
			amin_q <= 34'sh1_FFFF_FFFF;
			amax_q <= -34'sh1_FFFF_FFFF;
			bmin_q <= 34'sh1_FFFF_FFFF;
			bmax_q <= -34'sh1_FFFF_FFFF;
		end else if (cmd.proj_step) begin
			if (cmd.proj_b) begin
				if (proj < bmin_q) bmin_q <= proj;
				if (proj > bmax_q) bmax_q <= proj;
			end else begin
				if (proj < amin_q) amin_q <= proj;
				if (proj > amax_q) amax_q <= proj;
			end
		end
		if (cmd.axis_eval && (amin_q < bmax_q && bmin_q < amax_q)
		    && (!have_q || pen_c < best_q)) begin
			best_q <= pen_c;
			bux_q  <= ux_q;
			buy_q  <= uy_q;
		end
		// restart the sums on every edge so they begin at zero for the sum pass
		if (cmd.clear || cmd.edge_start) begin
			sax_q <= '0; say_q <= '0; sbx_q <= '0; sby_q <= '0;
		end else if (cmd.sum_step) begin
			if (cmd.sum_b) begin
				sbx_q <= sbx_q + 20'(signed'(sv[31:16]));
				sby_q <= sby_q + 20'(signed'(sv[15:0]));
			end else begin
				sax_q <= sax_q + 20'(signed'(sv[31:16]));
				say_q <= say_q + 20'(signed'(sv[15:0]));
			end
		end
		if (cmd.dir_calc) begin
			dx_q <= 25'(sax_q) * 25'(signed'({1'b0, cnt_b_q}))
				- 25'(sbx_q) * 25'(signed'({1'b0, cnt_a_q}));
			dy_q <= 25'(say_q) * 25'(signed'({1'b0, cnt_b_q}))
				- 25'(sby_q) * 25'(signed'({1'b0, cnt_a_q}));
		end
		if (cmd.push_calc) begin
			dot_q <= 42'(bux_q) * 42'(dx_q) + 42'(buy_q) * 42'(dy_q);
			px_q  <= 50'(bux_q) * 50'(best_q);
			py_q  <= 50'(buy_q) * 50'(best_q);
		end
		if (cmd.push_fin) begin
			out_x_q <= fin(px_q, dot_q[41]);
			out_y_q <= fin(py_q, dot_q[41]);
		end
		if (cmd.clear)
			collided_q <= 1'b0;
		else if (cmd.push_fin)
			collided_q <= 1'b1;
	end

	assign stat.count_a   = cnt_a_q;
	assign stat.count_b   = cnt_b_q;
	assign stat.edge_zero = (l2_q == '0);
	assign stat.sqrt_done = sq_busy_q && sq_bit_q == '0;
	assign stat.div_done  = dv_busy_q && dv_cnt_q == '0 && dv_sel_q;
	assign stat.separated = sep_q;
	assign stat.have      = have_q;
	assign res.collided   = collided_q;
	assign res.push_x     = have_q ? out_x_q : 16'h0;
	assign res.push_y     = have_q ? out_y_q : 16'h0;
endmodule

@@ src/spc_ctrl.sv @@
module spc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_action,
	output logic                out_valid,
	input  logic                out_ready,
	input  spc_pkg::dp_stat_t   stat,
	output spc_pkg::dp_cmd_t    cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EDGE = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_SQRT = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_PINI = 4'd5;
	localparam logic [3:0] S_PROJ = 4'd6;
	localparam logic [3:0] S_EVAL = 4'd7;
	localparam logic [3:0] S_NEXT = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_DIR  = 4'd10;
	localparam logic [3:0] S_PUSH = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;
	localparam logic [3:0] S_CLR  = 4'd14;

	logic [3:0] state_q;
	logic pass_q, pb_q, sb_q;
	logic [spc_pkg::IdxW-1:0] ei_q, pi_q, si_q;
	logic [spc_pkg::CntW-1:0] pn, sn, en;

	assign en = pass_q ? stat.count_b : stat.count_a;
	assign pn = pb_q ? stat.count_b : stat.count_a;
	assign sn = sb_q ? stat.count_b : stat.count_a;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.use_b    = pass_q;
		cmd.edge_idx = ei_q;
		cmd.proj_b   = pb_q;
		cmd.proj_idx = pi_q;
		cmd.sum_b    = sb_q;
		cmd.sum_idx  = si_q;
		cmd.load_a = in_valid && in_ready && in_action == spc_pkg::ACT_LOAD_A;
		cmd.load_b = in_valid && in_ready && in_action == spc_pkg::ACT_LOAD_B;
		unique case (state_q)
			S_EDGE: cmd.edge_start = 1'b1;
			S_CHK:  cmd.sqrt_start = !stat.edge_zero;
			S_SQRT: cmd.div_start = stat.sqrt_done;
			S_PINI: cmd.proj_start = 1'b1;
			S_PROJ: cmd.proj_step = 1'b1;
			S_EVAL: cmd.axis_eval = 1'b1;
			S_SUM:  cmd.sum_step = 1'b1;
			S_DIR:  cmd.dir_calc = 1'b1;
			S_PUSH: cmd.push_calc = 1'b1;
			S_FIN:  cmd.push_fin = 1'b1;
			// empty both polygons as the result transaction leaves
			S_OUT:  cmd.clear = out_ready;
			S_CLR:  cmd.clear = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= 1'b0; pb_q <= 1'b0; sb_q <= 1'b0;
			ei_q <= '0; pi_q <= '0; si_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid && in_action == spc_pkg::ACT_TEST) begin
					pass_q <= 1'b0;
					ei_q <= '0;
					state_q <= (stat.count_a == '0 || stat.count_b == '0) ? S_CLR : S_EDGE;
				end
				S_EDGE: state_q <= S_CHK;
				S_CHK:  state_q <= stat.edge_zero ? S_NEXT : S_SQRT;
				S_SQRT: if (stat.sqrt_done) state_q <= S_DIV;
				S_DIV:  if (stat.div_done) state_q <= S_PINI;
				S_PINI: begin
					pb_q <= 1'b0; pi_q <= '0; state_q <= S_PROJ;
				end
				S_PROJ: begin
					if ({1'b0, pi_q} + 1'b1 == pn) begin
						pi_q <= '0;
						if (pb_q) state_q <= S_EVAL;
						else pb_q <= 1'b1;
					end else pi_q <= pi_q + 1'b1;
				end
				S_EVAL: state_q <= S_NEXT;
				S_NEXT: begin
					pb_q <= 1'b0;
					if (stat.separated) state_q <= S_CLR;
					else if ({1'b0, ei_q} + 1'b1 == en) begin
						ei_q <= '0;
						if (pass_q) begin
							sb_q <= 1'b0; si_q <= '0;
							state_q <= stat.have ? S_SUM : S_FIN;
						end else begin
							pass_q <= 1'b1; state_q <= S_EDGE;
						end
					end else begin
						ei_q <= ei_q + 1'b1; state_q <= S_EDGE;
					end
				end
				S_SUM: begin
					if ({1'b0, si_q} + 1'b1 == sn) begin
						si_q <= '0;
						if (sb_q) state_q <= S_DIR;
						else sb_q <= 1'b1;
					end else si_q <= si_q + 1'b1;
				end
				S_DIR:  state_q <= S_PUSH;
				S_PUSH: state_q <= S_FIN;
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				S_CLR:  state_q <= S_OUT;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ src/sat_polygon_collision_core.sv @@
// Separating-axis collision test for two convex polygons. Actions 0 and 1
// append a vertex (Q8.8) to polygon A or B; up to 8 each, extras
// dropped. Action 2 runs the test and emits one transaction, then empties
// both polygons once that transaction is taken. Each edge with nonzero length
// runs the bit-serial square root, then the restoring divider (x, then y,
// with a turnaround and a done step), then projects every vertex of A and B,
// with states of control around them; a zero-length edge skips to the next
// edge. A colliding result then runs the centroid sums and the push; a
// separated or empty case goes through the clear state. One item is in flight
// at a time, so the input stalls from the test until its result transaction
// is accepted.
module sat_polygon_collision_core (
	input logic clk,
	input logic arst_n,
	spc_if.sink   in_ch,
	spc_if.source out_ch
);
	spc_pkg::dp_cmd_t   cmd;
	spc_pkg::dp_stat_t  stat;
	spc_pkg::out_item_t res;

	spc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_action(in_ch.data.action),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat, .cmd
	);

	spc_datapath u_dp (
		.clk, .arst_n, .cmd,
		.in_x(in_ch.data.coord_x), .in_y(in_ch.data.coord_y),
		.stat, .res
	);

	assign out_ch.data = res;
endmodule

@@ src/spc_checker.sv @@
module spc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic collided,
	input logic [15:0] push_x,
	input logic [15:0] push_y
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_nocoll_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !collided |-> push_x == '0 && push_y == '0)
		else $error("push nonzero without collision");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(push_x) && $stable(push_y))
		else $error("result dropped");
endmodule

bind sat_polygon_collision_core spc_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.collided(out_ch.data.collided), .push_x(out_ch.data.push_x),
	.push_y(out_ch.data.push_y)
);

@@ sim/sat_polygon_collision_core_tb.sv @@
`timescale 1ns / 100ps

class collision_scoreboard;
	logic [31:0] poly_a[spc_pkg::MaxVerts];
	logic [31:0] poly_b[spc_pkg::MaxVerts];
	int unsigned cnt_a;
	int unsigned cnt_b;
	spc_pkg::out_item_t pending[$];
	int          errors;
	int          tests;
	int          hits;

	function new();
		foreach (poly_a[i]) begin
			poly_a[i] = '0;
			poly_b[i] = '0;
		end
		cnt_a = 0;
		cnt_b = 0;
		errors = 0;
		tests = 0;
		hits = 0;
	endfunction

	function longint vert_x(logic [31:0] w);
		return longint'($signed(w[31:16]));
	endfunction

	function longint vert_y(logic [31:0] w);
		return longint'($signed(w[15:0]));
	endfunction

	function logic [31:0] vert(bit use_b, int unsigned i);
		return use_b ? poly_b[i] : poly_a[i];
	endfunction

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function void project(bit use_b, longint ux, longint uy, output longint lo,
			output longint hi);
		int unsigned n;
		longint p;
		n = use_b ? cnt_b : cnt_a;
		for (int unsigned i = 0; i < n; i++) begin
			p = vert_x(vert(use_b, i)) * ux + vert_y(vert(use_b, i)) * uy;
			if (i == 0 || p < lo)
				lo = p;
			if (i == 0 || p > hi)
				hi = p;
		end
	endfunction

	// 0 separated, 1 overlap, 2 degenerate edge
	function int axis_overlap(bit use_b, int unsigned i, output longint pen,
			output longint ux, output longint uy);
		int unsigned n;
		int unsigned j;
		longint nx;
		longint ny;
		longint lenq;
		longint amin, amax, bmin, bmax, p1, p2;
		n = use_b ? cnt_b : cnt_a;
		j = (i + 1 == n) ? 0 : i + 1;
		nx = -(vert_y(vert(use_b, j)) - vert_y(vert(use_b, i)));
		ny = vert_x(vert(use_b, j)) - vert_x(vert(use_b, i));
		if (nx * nx + ny * ny == 0)
			return 2;
		lenq = longint'(int_sqrt(longint'(nx * nx + ny * ny) << 16));
		ux = (nx * 4194304) / lenq;
		uy = (ny * 4194304) / lenq;
		project(1'b0, ux, uy, amin, amax);
		project(1'b1, ux, uy, bmin, bmax);
		if (!(amin < bmax && bmin < amax))
			return 0;
		p1 = amax - bmin;
		p2 = bmax - amin;
		pen = (p2 < p1) ? p2 : p1;
		return 1;
	endfunction

	function longint round_q88(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 << 27)) >>> 28;
		return (v < 0) ? -m : m;
	endfunction

	function logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function spc_pkg::out_item_t separation_test();
		spc_pkg::out_item_t res;
		longint best, bux, buy, pen, ux, uy;
		longint sax, say, sbx, sby, dx, dy, px, py;
		bit have;
		int r;
		res = '0;
		have = 0;
		best = 0;
		bux = 0;
		buy = 0;
		if (cnt_a == 0 || cnt_b == 0)
			return res;
		for (int ps = 0; ps < 2; ps++) begin
			for (int unsigned i = 0; i < (ps ? cnt_b : cnt_a); i++) begin
				r = axis_overlap(ps[0], i, pen, ux, uy);
				if (r == 0)
					return res;
				if (r == 1 && (!have || pen < best)) begin
					have = 1;
					best = pen;
					bux = ux;
					buy = uy;
				end
			end
		end
		res.collided = 1'b1;
		if (have) begin
			sax = 0; say = 0; sbx = 0; sby = 0;
			for (int unsigned i = 0; i < cnt_a; i++) begin
				sax += vert_x(poly_a[i]);
				say += vert_y(poly_a[i]);
			end
			for (int unsigned i = 0; i < cnt_b; i++) begin
				sbx += vert_x(poly_b[i]);
				sby += vert_y(poly_b[i]);
			end
			dx = longint'(cnt_b) * sax - longint'(cnt_a) * sbx;
			dy = longint'(cnt_b) * say - longint'(cnt_a) * sby;
			px = round_q88(bux * best);
			py = round_q88(buy * best);
			// point the push from B toward A
			if (bux * dx + buy * dy < 0) begin
				px = -px;
				py = -py;
			end
			res.push_x = clamp16(px);
			res.push_y = clamp16(py);
		end
		return res;
	endfunction

	function void note_input(spc_pkg::in_item_t it);
		case (it.action)
			spc_pkg::ACT_LOAD_A: begin
				if (cnt_a < spc_pkg::MaxVerts)
					poly_a[cnt_a++] = {it.coord_x, it.coord_y};
			end
			spc_pkg::ACT_LOAD_B: begin
				if (cnt_b < spc_pkg::MaxVerts)
					poly_b[cnt_b++] = {it.coord_x, it.coord_y};
			end
			spc_pkg::ACT_TEST: begin
				pending.insert(pending.size(), separation_test());
				cnt_a = 0;
				cnt_b = 0;
			end
			default: ;
		endcase
	endfunction

	function void check_result(spc_pkg::out_item_t got);
		spc_pkg::out_item_t exp;
		if (pending.size() == 0) begin
			$error("unexpected result transaction %h", got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		tests++;
		if (got.collided)
			hits++;
		if (got.collided !== exp.collided) begin
			$error("collided: expected %0d, got %0d", exp.collided, got.collided);
			errors++;
		end
		if (got.push_x !== exp.push_x) begin
			$error("push_x: expected %0d, got %0d", exp.push_x, got.push_x);
			errors++;
		end
		if (got.push_y !== exp.push_y) begin
			$error("push_y: expected %0d, got %0d", exp.push_y, got.push_y);
			errors++;
		end
	endfunction
endclass

module sat_polygon_collision_core_tb;
	logic clk;
	logic arst_n;
	logic hold_off;
	int   burst_left;
	int   sent;
	int   stall_mode;

	collision_scoreboard sb;

	spc_if #(.payload_t(spc_pkg::in_item_t))  in_ch ();
	spc_if #(.payload_t(spc_pkg::out_item_t)) out_ch ();

	sat_polygon_collision_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

	// long receiver hold-off so the block backs up into the input
	initial begin
		hold_off = 1'b0;
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (5000) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		out_ch.ready = 1'b0;
		stall_mode = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.data);
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_ch.ready <= !hold_off;
				1: out_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= !hold_off && ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	task automatic send(logic [1:0] act, int x, int y);
		spc_pkg::in_item_t it;
		it.action = act;
		it.coord_x = x[15:0];
		it.coord_y = y[15:0];
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_input(it);
		burst_left--;
		sent++;
	endtask

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	task automatic send_shape(logic [1:0] act, int n, int cx, int cy, int r);
		for (int i = 0; i < n; i++)
			send(act, cx + rnd(-r, r), cy + rnd(-r, r));
	endtask

	initial begin
		int cx, cy, r, k;
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		burst_left = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty polygons, then B empty only
		send(spc_pkg::ACT_TEST, 32767, -32768);
		send(spc_pkg::ACT_LOAD_A, -32768, -32768);
		send(spc_pkg::ACT_TEST, 0, 0);
		send(spc_pkg::ACT_NOP, -1, 32767);
		// every edge degenerate: no axis at all
		repeat (3) send(spc_pkg::ACT_LOAD_A, 256, -256);
		repeat (3) send(spc_pkg::ACT_LOAD_B, 256, -256);
		send(spc_pkg::ACT_TEST, 0, 0);
		// extreme square around a small triangle: saturated push
		send(spc_pkg::ACT_LOAD_A, 32767, 32767);
		send(spc_pkg::ACT_LOAD_A, -32768, 32767);
		send(spc_pkg::ACT_LOAD_A, -32768, -32768);
		send(spc_pkg::ACT_LOAD_A, 32767, -32768);
		send(spc_pkg::ACT_LOAD_B, 0, 0);
		send(spc_pkg::ACT_LOAD_B, 512, 0);
		send(spc_pkg::ACT_LOAD_B, 0, 512);
		send(spc_pkg::ACT_TEST, 0, 0);

		while (sent < 550) begin
			k = $urandom_range(0, 99);
			if (k < 85) begin
				cx = rnd(-3000, 3000);
				cy = rnd(-3000, 3000);
				r = ($urandom_range(0, 9) == 0) ? 30000 : rnd(100, 2000);
				send_shape(spc_pkg::ACT_LOAD_A,
					($urandom_range(0, 7) == 0) ? rnd(5, 10) : rnd(3, 4), cx, cy, r);
				send_shape(spc_pkg::ACT_LOAD_B,
					($urandom_range(0, 7) == 0) ? rnd(5, 10) : rnd(3, 4),
					cx + rnd(-r, r), cy + rnd(-r, r), r);
				send(spc_pkg::ACT_TEST, rnd(-32768, 32767), rnd(-32768, 32767));
			end else if (k < 92) begin
				send(($urandom_range(0, 1) != 0) ? spc_pkg::ACT_LOAD_B : spc_pkg::ACT_LOAD_A,
					rnd(-32768, 32767), rnd(-32768, 32767));
			end else if (k < 96) begin
				send(spc_pkg::ACT_NOP, rnd(-32768, 32767), rnd(-32768, 32767));
			end else begin
				send(spc_pkg::ACT_TEST, rnd(-32768, 32767), rnd(-32768, 32767));
			end
		end
		in_ch.valid <= 1'b0;

		k = 0;
		while (sb.pending.size() != 0 && k < 400_000) begin
			@(posedge clk);
			k++;
		end
		repeat (300) @(posedge clk);

		$display("Sent %0d transactions; checked %0d collision tests, %0d with contact.",
			sent, sb.tests, sb.hits);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
